// ----- sv/qdb_pkg.sv -----
// shared types and constants of the quadrature decoder and button debounce block
`timescale 1ns / 1ps
`default_nettype none
package qdb_pkg;

  // number of channels (1 to 32); only the first eight have mask and pin bits
  localparam int CHANNELS = 8;
  localparam int ChIdxW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ExtW     = (CHANNELS > 8) ? CHANNELS : 8;

  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  localparam logic [7:0] ResetReload = 8'd3;
  localparam logic [7:0] ResetPeriod = 8'd75;
  localparam logic [7:0] CountWrap   = 8'hff;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_READ_COUNT  = 2'd1,
    OP_READ_BUTTON = 2'd2
  } qdb_op_e;

  typedef enum logic [1:0] {
    REG_ROT_MASK      = 2'd0,
    REG_BTN_MASK      = 2'd1,
    REG_RELOAD        = 2'd2,
    REG_SAMPLE_PERIOD = 2'd3
  } qdb_reg_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] channel;
    logic [7:0] phase_a_pins;
    logic [7:0] phase_b_pins;
    logic [7:0] button_pins;
    logic       clear_flag;
  } qdb_in_t;

  typedef struct packed {
    logic signed [13:0] detent_count;
    logic               button_pressed;
  } qdb_out_t;

  typedef struct packed {
    logic [7:0] rot_mask;
    logic [7:0] btn_mask;
    logic [7:0] reload;
    logic [7:0] period;
  } qdb_cfg_t;

  typedef struct packed {
    logic       tick;
    logic       sample;
    logic       rot_en;
    logic       btn_en;
    logic       pin_a;
    logic       pin_b;
    logic       pin_btn;
    logic       count_clr;
    logic       flag_clr;
    logic [7:0] reload;
  } qdb_chan_ctrl_t;

endpackage
`default_nettype wire

// ----- sv/qdb_if.sv -----
// valid/ready stream interfaces for input items and result items
`timescale 1ns / 1ps
`default_nettype none
interface qdb_in_if;
  import qdb_pkg::*;
  logic    valid;
  logic    ready;
  qdb_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface qdb_out_if;
  import qdb_pkg::*;
  logic     valid;
  logic     ready;
  qdb_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- sv/qdb_regs.sv -----
// apb configuration registers
`timescale 1ns / 1ps
`default_nettype none
module qdb_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [qdb_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [qdb_pkg::ApbDataW-1:0] pwdata,
  output logic      [qdb_pkg::ApbDataW-1:0] prdata,
  output logic                              pready,
  output qdb_pkg::qdb_cfg_t                 cfg_o
);
  import qdb_pkg::*;

  qdb_cfg_t cfg_q, cfg_d;
  qdb_reg_e reg_sel;
  logic     wr_en;
  logic [7:0] rd_val;

  assign reg_sel = qdb_reg_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_ROT_MASK:      cfg_d.rot_mask = pwdata[7:0];
        REG_BTN_MASK:      cfg_d.btn_mask = pwdata[7:0];
        REG_RELOAD:        cfg_d.reload   = pwdata[7:0];
        REG_SAMPLE_PERIOD: cfg_d.period   = pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ROT_MASK:      rd_val = cfg_q.rot_mask;
      REG_BTN_MASK:      rd_val = cfg_q.btn_mask;
      REG_RELOAD:        rd_val = cfg_q.reload;
      REG_SAMPLE_PERIOD: rd_val = cfg_q.period;
    endcase
  end

  assign prdata = ApbDataW'(rd_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_mask <= 8'd0;
      cfg_q.btn_mask <= 8'd0;
      cfg_q.reload   <= ResetReload;
      cfg_q.period   <= ResetPeriod;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ----- sv/qdb_channel.sv -----
// per-channel encoder step accumulator and button debouncer
`timescale 1ns / 1ps
`default_nettype none
module qdb_channel (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire qdb_pkg::qdb_chan_ctrl_t ctrl_i,
  output logic [15:0]                  acc_o,
  output logic                         latch_o
);
  import qdb_pkg::*;

  logic [1:0]  phase_q, phase_d, phase_now, diff;
  logic        primed_q, primed_d;
  logic [15:0] acc_q, acc_d;
  logic        level_q, level_d, level_now;
  logic [7:0]  cnt_q, cnt_d, cnt_dec;
  logic        latch_q, latch_d;

  // (a ? 3 : 0) ^ b
  assign phase_now = {ctrl_i.pin_a, ctrl_i.pin_a ^ ctrl_i.pin_b};
  assign diff      = phase_q - phase_now;
  assign level_now = ~ctrl_i.pin_btn;
  assign cnt_dec   = cnt_q - 8'd1;

  always_comb begin
    phase_d  = phase_q;
    primed_d = primed_q;
    acc_d    = acc_q;
    if (ctrl_i.tick && ctrl_i.rot_en) begin
      if (!primed_q) begin
        phase_d  = phase_now;
        primed_d = 1'b1;
      end else if (diff[0]) begin
        phase_d = phase_now;
        acc_d   = diff[1] ? acc_q + 16'd1 : acc_q - 16'd1;
      end
    end else if (ctrl_i.count_clr) begin
      acc_d = {14'd0, acc_q[1:0]};
    end
  end

  always_comb begin
    level_d = level_q;
    cnt_d   = cnt_q;
    latch_d = latch_q;
    if (ctrl_i.tick && ctrl_i.sample && ctrl_i.btn_en) begin
      if (level_now != level_q) begin
        if (cnt_dec == CountWrap) begin
          cnt_d   = ctrl_i.reload;
          level_d = level_now;
          latch_d = level_now;
        end else begin
          cnt_d = cnt_dec;
        end
      end else begin
        cnt_d = ctrl_i.reload;
      end
    end else if (ctrl_i.flag_clr) begin
      latch_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 2'd0;
      primed_q <= 1'b0;
      acc_q    <= 16'd0;
      level_q  <= 1'b0;
      cnt_q    <= 8'd0;
      latch_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      primed_q <= primed_d;
      acc_q    <= acc_d;
      level_q  <= level_d;
      cnt_q    <= cnt_d;
      latch_q  <= latch_d;
    end
  end

  assign acc_o   = acc_q;
  assign latch_o = latch_q;

endmodule
`default_nettype wire

// ----- sv/quadrature_decoder_button_debounce.sv -----
// top level: quadrature decoder and button debounce front end
//
// multi-channel rotary encoder front end. an input transfer with opcode tick
// samples the a/b pins of every channel enabled in rotary_enable_mask and
// steps that channel's 16-bit wrapping accumulator by +1 or -1 on a single
// gray-code move (the first tick after reset only records the phase); every
// button_sample_period-th tick also debounces the active-low buttons enabled
// in button_enable_mask with a reload counter and latches a press flag. a
// count read returns the accumulator shifted right by two (arithmetic) and
// keeps its low two bits; a disabled or absent channel reads zero. a button
// read returns the press flag and clears it when clear_flag is set. ticks
// and opcode 3 give no result transfer; reads give exactly one. the block
// takes one item every cycle unless the output register holds it up: an
// item is captured in the input register and processed against the channel
// state from there, and a read's result is then registered in the output
// register, where it stays valid until the sink takes it. the output
// register only holds up the input side when a read meets a result that the
// sink has not yet taken. configuration is written through the apb port
// (registers at byte offsets 0, 4, 8, 12, pready always high) and should
// change only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module quadrature_decoder_button_debounce (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [qdb_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [qdb_pkg::ApbDataW-1:0] pwdata,
  output logic      [qdb_pkg::ApbDataW-1:0] prdata,
  output logic                              pready,
  qdb_in_if.sink                            in_if,
  qdb_out_if.source                         out_if
);
  import qdb_pkg::*;

  qdb_cfg_t cfg;

  // input register
  logic    in_valid_q, in_valid_d;
  qdb_in_t in_q;

  // result register
  logic     out_valid_q, out_valid_d;
  qdb_out_t out_q, res;

  // prescaler for the button sample period
  logic [7:0] presc_q, presc_d, presc_inc;

  logic is_tick, is_cnt_rd, is_btn_rd, has_res, advance, sample, ch_ok;
  logic [ChIdxW-1:0] ch_idx;
  logic [ExtW-1:0]   rot_en_ext, btn_en_ext, pa_ext, pb_ext, pbtn_ext;
  logic [15:0]       acc_arr [CHANNELS];
  logic [CHANNELS-1:0] latch_vec;

  qdb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // decode of the registered item
  assign is_tick   = in_valid_q && (in_q.opcode == OP_TICK);
  assign is_cnt_rd = in_valid_q && (in_q.opcode == OP_READ_COUNT);
  assign is_btn_rd = in_valid_q && (in_q.opcode == OP_READ_BUTTON);
  assign has_res   = is_cnt_rd || is_btn_rd;

  // the item moves on unless it needs the result register while that is full and not being taken
  assign advance   = in_valid_q && (!has_res || !out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;

  assign in_valid_d = in_if.valid ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_q <= in_if.payload;
    end
  end

  // prescaler wraps mod 256 and clears on reaching the period
  assign presc_inc = presc_q + 8'd1;
  always_comb begin
    presc_d = presc_q;
    if (is_tick) begin
      presc_d = (presc_inc == cfg.period) ? 8'd0 : presc_inc;
    end
  end
  assign sample = (presc_d == 8'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q <= 8'd0;
    end else begin
      presc_q <= presc_d;
    end
  end

  // channels above 7 see zero mask and pin bits
  assign rot_en_ext = ExtW'(cfg.rot_mask);
  assign btn_en_ext = ExtW'(cfg.btn_mask);
  assign pa_ext     = ExtW'(in_q.phase_a_pins);
  assign pb_ext     = ExtW'(in_q.phase_b_pins);
  assign pbtn_ext   = ExtW'(in_q.button_pins);

  assign ch_ok  = (32'(in_q.channel) < 32'(CHANNELS));
  assign ch_idx = ChIdxW'(in_q.channel);

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    qdb_chan_ctrl_t ctrl;
    logic           sel;

    assign sel = ch_ok && (32'(in_q.channel) == 32'(i));

    assign ctrl.tick      = is_tick;
    assign ctrl.sample    = sample;
    assign ctrl.rot_en    = rot_en_ext[i];
    assign ctrl.btn_en    = btn_en_ext[i];
    assign ctrl.pin_a     = pa_ext[i];
    assign ctrl.pin_b     = pb_ext[i];
    assign ctrl.pin_btn   = pbtn_ext[i];
    assign ctrl.count_clr = advance && is_cnt_rd && sel && rot_en_ext[i];
    assign ctrl.flag_clr  = advance && is_btn_rd && sel && in_q.clear_flag;
    assign ctrl.reload    = cfg.reload;

    qdb_channel u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .acc_o  (acc_arr[i]),
      .latch_o(latch_vec[i])
    );
  end

  // result of a read: shifted count or latched flag, zero when not applicable
  always_comb begin
    res = '0;
    if (ch_ok) begin
      if (is_cnt_rd && rot_en_ext[ch_idx]) begin
        res.detent_count = acc_arr[ch_idx][15:2];
      end
      if (is_btn_rd) begin
        res.button_pressed = latch_vec[ch_idx];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && has_res) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_res) begin
      out_q <= res;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// self-checking testbench for the quadrature decoder and button debounce block
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import qdb_pkg::*;

  // opcode 3 has no enum member; the block must drop it without a result
  localparam logic [1:0] OpUnused = 2'd3;
  // input register plus output register, with some margin
  localparam int SettleCycles = 6;
  // the slowest correct run stays well under this limit
  localparam int unsigned CycleLimit = 400000;
  localparam int PhaseItems = 100;

  // predictor of the block plus the queue of results it still owes
  class detent_scoreboard;
    logic [7:0]  rot_mask;
    logic [7:0]  btn_mask;
    logic [7:0]  reload;
    logic [7:0]  period;
    logic [1:0]  last_phase [CHANNELS];
    bit          primed [CHANNELS];
    logic [15:0] steps [CHANNELS];
    bit          level [CHANNELS];
    logic [7:0]  bounce [CHANNELS];
    bit          latch [CHANNELS];
    logic [7:0]  prescale;
    qdb_out_t    pending [$];
    int          errors;

    function new();
      rot_mask = '0;
      btn_mask = '0;
      reload   = ResetReload;
      period   = ResetPeriod;
      prescale = '0;
      errors   = 0;
      for (int c = 0; c < CHANNELS; c++) begin
        last_phase[c] = '0;
        primed[c]     = 1'b0;
        steps[c]      = '0;
        level[c]      = 1'b0;
        bounce[c]     = '0;
        latch[c]      = 1'b0;
      end
    endfunction

    function void set_reg(qdb_reg_e idx, logic [7:0] val);
      case (idx)
        REG_ROT_MASK:      rot_mask = val;
        REG_BTN_MASK:      btn_mask = val;
        REG_RELOAD:        reload   = val;
        REG_SAMPLE_PERIOD: period   = val;
        default:           ;
      endcase
    endfunction

    function void advance_tick(logic [7:0] a, logic [7:0] b, logic [7:0] btn);
      logic [1:0] ph;
      logic [1:0] diff;
      logic       lvl;
      bit         sample;
      prescale = prescale + 8'd1;
      if (prescale == period) prescale = '0;
      sample = (prescale == '0);
      for (int c = 0; c < CHANNELS && c < 8; c++) begin
        if (rot_mask[c]) begin
          // a high maps to 3, then b flips the low bit
          ph = {a[c], a[c] ^ b[c]};
          if (!primed[c]) begin
            last_phase[c] = ph;
            primed[c]     = 1'b1;
          end else begin
            diff = last_phase[c] - ph;
            // odd move is one step, even move (hold or skipped state) is dropped
            if (diff[0]) begin
              last_phase[c] = ph;
              steps[c] = diff[1] ? steps[c] + 16'd1 : steps[c] - 16'd1;
            end
          end
        end
        if (sample && btn_mask[c]) begin
          lvl = ~btn[c];
          if (lvl != level[c]) begin
            bounce[c] = bounce[c] - 8'd1;
            if (bounce[c] == CountWrap) begin
              bounce[c] = reload;
              level[c]  = lvl;
              latch[c]  = lvl;
            end
          end else begin
            bounce[c] = reload;
          end
        end
      end
    endfunction

    function void note_input(qdb_in_t item);
      qdb_out_t    res;
      logic [15:0] shifted;
      int          c;
      c   = int'(item.channel);
      res = '0;
      case (item.opcode)
        OP_TICK: begin
          advance_tick(item.phase_a_pins, item.phase_b_pins, item.button_pins);
        end
        OP_READ_COUNT: begin
          if (c < CHANNELS && c < 8 && rot_mask[c]) begin
            shifted          = $signed(steps[c]) >>> 2;
            res.detent_count = shifted[13:0];
            steps[c]         = steps[c] & 16'd3;
          end
          pending.push_back(res);
        end
        OP_READ_BUTTON: begin
          if (c < CHANNELS) begin
            res.button_pressed = latch[c];
            if (item.clear_flag) latch[c] = 1'b0;
          end
          pending.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(qdb_out_t got);
      qdb_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual count %0d pressed %0b",
                 $time, $signed(got.detent_count), got.button_pressed);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.detent_count !== want.detent_count) begin
        $display("%0t: detent_count expected %0d actual %0d",
                 $time, $signed(want.detent_count), $signed(got.detent_count));
        errors++;
      end
      if (got.button_pressed !== want.button_pressed) begin
        $display("%0t: button_pressed expected %0b actual %0b",
                 $time, want.button_pressed, got.button_pressed);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  qdb_in_if  in_bus ();
  qdb_out_if out_bus ();

  quadrature_decoder_button_debounce u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (in_bus),
    .out_if  (out_bus)
  );

  detent_scoreboard sb;
  // when set, neither side inserts idle cycles
  bit          calm;
  int unsigned cycle_count;

  // per-channel pin history for the random encoder walk
  bit [1:0] pin_phase [8];
  bit [7:0] turn_dir;
  bit [7:0] btn_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a stuck handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic qdb_in_t make_item(logic [1:0] op, logic [2:0] ch, logic [7:0] a,
                                        logic [7:0] b, logic [7:0] btn, logic clr);
    qdb_in_t item;
    item.opcode       = op;
    item.channel      = ch;
    item.phase_a_pins = a;
    item.phase_b_pins = b;
    item.button_pins  = btn;
    item.clear_flag   = clr;
    return item;
  endfunction

  // random tick: mostly single gray-code moves per channel, with holds,
  // skipped states and noise; buttons are held levels with short glitches
  function automatic qdb_in_t next_tick();
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] btn;
    int         r;
    for (int c = 0; c < 8; c++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        pin_phase[c] = turn_dir[c] ? pin_phase[c] + 2'd1 : pin_phase[c] - 2'd1;
      end else if (r < 80) begin
        pin_phase[c] = pin_phase[c] + 2'd2;
      end else if (r < 90) begin
        pin_phase[c] = 2'($urandom_range(0, 3));
      end
      if ($urandom_range(0, 19) == 0) turn_dir[c] = ~turn_dir[c];
      a[c] = pin_phase[c][1];
      b[c] = pin_phase[c][1] ^ pin_phase[c][0];
    end
    if ($urandom_range(0, 9) == 0) btn_hold[$urandom_range(0, 7)] ^= 1'b1;
    btn = btn_hold;
    if ($urandom_range(0, 4) == 0) btn[$urandom_range(0, 7)] ^= 1'b1;
    return make_item(OP_TICK, 3'($urandom_range(0, 7)), a, b, btn,
                     1'($urandom_range(0, 1)));
  endfunction

  // one input transfer; valid stays high across back-to-back items
  task automatic send_item(qdb_in_t item);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.payload <= item;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sb.note_input(item);
  endtask

  // tick with the same encoder phase on every channel
  task automatic send_phase(logic [1:0] ph, logic [7:0] btn);
    send_item(make_item(OP_TICK, 3'd0, {8{ph[1]}}, {8{ph[1] ^ ph[0]}}, btn, 1'b0));
  endtask

  // stop sending, wait for every owed result, then let ticks in flight retire
  task automatic settle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic reg_write(qdb_reg_e idx, logic [7:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= ApbDataW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(logic [7:0] rot, logic [7:0] btn, logic [7:0] rel,
                           logic [7:0] per);
    reg_write(REG_ROT_MASK, rot);
    reg_write(REG_BTN_MASK, btn);
    reg_write(REG_RELOAD, rel);
    reg_write(REG_SAMPLE_PERIOD, per);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_item(next_tick());
    end else if (r < 75) begin
      send_item(make_item(OP_READ_COUNT, 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    end else if (r < 95) begin
      send_item(make_item(OP_READ_BUTTON, 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    end else begin
      send_item(make_item(OpUnused, 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    end
  endtask

  // result side: random stall before each transfer, then check it
  initial begin : result_sink
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 6);
      @(negedge clk_i);
      if (gap != 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (out_bus.valid !== 1'b1);
      sb.check_result(out_bus.payload);
    end
  end

  initial begin : main
    logic [1:0] spin_ph;
    sb = new();
    calm = 1'b0;
    turn_dir = '0;
    btn_hold = 8'hff;
    for (int c = 0; c < 8; c++) pin_phase[c] = '0;
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_bus.valid    <= 1'b0;
    in_bus.payload  <= '0;
    out_bus.ready   <= 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset config: every channel disabled, count reads give zero
    send_item(make_item(OP_READ_COUNT, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_item(make_item(OP_READ_BUTTON, 3'd7, 8'h00, 8'h00, 8'h00, 1'b1));
    // unused opcode is dropped without a result
    send_item(make_item(OpUnused, 3'd7, 8'hff, 8'hff, 8'hff, 1'b1));
    settle();

    // all channels on, zero reload (first differing sample wins), sample every tick
    configure(8'hff, 8'hff, 8'd0, 8'd1);
    send_phase(2'd0, 8'hff);  // first tick only primes the phase
    send_phase(2'd1, 8'hff);
    send_phase(2'd2, 8'h00);  // press taken on its first sample
    send_phase(2'd3, 8'h00);
    send_item(make_item(OP_READ_BUTTON, 3'd3, 8'h00, 8'h00, 8'h00, 1'b0));
    send_item(make_item(OP_READ_BUTTON, 3'd3, 8'h00, 8'h00, 8'h00, 1'b1));
    send_item(make_item(OP_READ_BUTTON, 3'd3, 8'h00, 8'h00, 8'h00, 1'b0));
    send_phase(2'd0, 8'h00);  // four forward steps: one detent
    send_item(make_item(OP_READ_COUNT, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_phase(2'd3, 8'hff);  // backward below zero; release clears the latch
    send_item(make_item(OP_READ_COUNT, 3'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_phase(2'd2, 8'hff);
    send_phase(2'd0, 8'hff);  // skipped state, ignored
    send_item(make_item(OP_READ_COUNT, 3'd5, 8'hff, 8'hff, 8'hff, 1'b1));
    send_item(make_item(OP_READ_BUTTON, 3'd5, 8'hff, 8'hff, 8'hff, 1'b1));
    settle();

    // forward spin with no idle cycles; period 0 samples every 256 ticks
    configure(8'hff, 8'hff, 8'd2, 8'd0);
    calm = 1'b1;
    for (int c = 0; c < 8; c++) begin
      send_item(make_item(OP_READ_COUNT, 3'(c), 8'h00, 8'h00, 8'h00, 1'b0));
    end
    // channels now hold 0..3 before the spin
    spin_ph = 2'd2;
    for (int n = 0; n < 300; n++) begin
      spin_ph = spin_ph + 2'd1;
      send_phase(spin_ph, (n[7]) ? 8'hff : 8'h00);
    end
    for (int c = 0; c < 4; c++) begin
      send_item(make_item(OP_READ_COUNT, 3'(c), 8'h00, 8'h00, 8'h00, 1'b0));
    end
    // four more steps, read channels restart from their low bits
    for (int n = 0; n < 4; n++) begin
      spin_ph = spin_ph + 2'd1;
      send_phase(spin_ph, 8'hff);
    end
    for (int c = 0; c < 8; c++) begin
      send_item(make_item(OP_READ_COUNT, 3'(c), 8'h00, 8'h00, 8'h00, 1'b0));
    end
    calm = 1'b0;
    // keep the random walk in step with the pins last driven
    for (int c = 0; c < 8; c++) pin_phase[c] = spin_ph;

    // random phases, each under its own setting; drain before every change
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: configure(8'hff, 8'hff, 8'd0, 8'd1);
        1: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'hff, 8'hff);
        2: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 3)), 8'($urandom_range(1, 3)));
        3: configure(8'h00, 8'h00, 8'd3, 8'd0);
        4: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(1, 4)), 8'($urandom_range(1, 5)));
        default: configure(8'hff, 8'hff, 8'd1, 8'd2);
      endcase
      // last phase runs without any idle cycles on either side
      calm = (p == 5);
      for (int n = 0; n < PhaseItems; n++) random_item();
    end
    calm = 1'b0;
    settle();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
